### rtl/core/rcmgc_pkg.sv
`default_nettype none

package rcmgc_pkg;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ID_W      = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned BIT_IDX_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NS_REGS   = 4;

  localparam logic [REG_W-1:0]   SAFE_STOPPED_A = 32'hFFFF_FFF0;
  localparam logic [REG_W-1:0]   ALL_STOPPED    = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    OP_ENABLE  = 2'd0,
    OP_DISABLE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_REINIT  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_BAD_STATE = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_PATTERN_A = 3'd0,
    CFG_NS_MASK_B      = 3'd1,
    CFG_NS_MASK_C      = 3'd2,
    CFG_NS_MASK_D      = 3'd3,
    CFG_NS_MASK_E      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

endpackage

`default_nettype wire

### rtl/core/refcounted_module_gate_control.sv
// The count store is read in the accept cycle; the result is computed, written back
// and registered when the execute step completes, which a stalled result can delay.
// Each word is a read-modify-write of the count store, and no new word is taken until
// it is through: input stalls outside idle, and a stalled result holds the execute step.
// Reset is asynchronous and active low; it clears every count through per-entry
// valid bits at once and restores the stop registers and masks.
`default_nettype none

module refcounted_module_gate_control #(
  parameter int unsigned GATE_REGISTERS    = 5,
  parameter int unsigned BITS_PER_REGISTER = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcmgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcmgc_pkg::REG_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rcmgc_pkg::KIND_W-1:0]     in_kind_i,
  input  logic [rcmgc_pkg::ID_W-1:0]       in_module_id_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rcmgc_pkg::STATUS_W-1:0]   out_status_o,
  output logic [rcmgc_pkg::COUNT_W-1:0]    out_use_count_o,
  output logic                             out_halted_o
);
  import rcmgc_pkg::*;

  localparam int unsigned RW    = (GATE_REGISTERS > 1) ? $clog2(GATE_REGISTERS) : 1;
  localparam int unsigned BW    = (BITS_PER_REGISTER > 1) ? $clog2(BITS_PER_REGISTER) : 1;
  localparam int unsigned AW    = RW + BW;
  localparam int unsigned DEPTH = 2 ** AW;

  state_e             state_q, state_d;
  op_e                kind_q;
  logic [7:0]         reg_q;
  logic [7:0]         bit_q;
  logic               id_ok_q;
  logic [AW-1:0]      addr_q;

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_q;
  logic [DEPTH-1:0]   cnt_vld_q;

  logic [REG_W-1:0]   stop_q [GATE_REGISTERS];
  logic [REG_W-1:0]   init_a_q;
  logic [REG_W-1:0]   ns_mask_q [NS_REGS];

  logic               out_valid_q, out_halted_q;
  status_e            out_status_q;
  logic [COUNT_W-1:0] out_count_q;

  logic               accept;
  logic               exec_done;
  logic [7:0]         in_reg, in_bit;
  logic               in_id_ok;
  logic [AW-1:0]      in_addr;

  logic [REG_W-1:0]   ns_of [GATE_REGISTERS];
  logic [REG_W-1:0]   reinit_val [GATE_REGISTERS];
  logic [RW-1:0]      r_idx;
  logic [REG_W-1:0]   bit_mask, stop_old, stop_cand, stop_new;
  logic [COUNT_W-1:0] cnt_prev, cnt_new;
  logic               mem_we, stop_wr, stopped_res;
  status_e            status_res;

  assign in_reg   = in_module_id_i[15:8];
  assign in_bit   = in_module_id_i[7:0];
  assign in_id_ok = (32'(in_reg) < GATE_REGISTERS) && (32'(in_bit) < BITS_PER_REGISTER);
  assign in_addr  = {in_reg[RW-1:0], in_bit[BW-1:0]};

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign exec_done  = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < GATE_REGISTERS; i++) begin
      if (i >= 1 && i <= NS_REGS) begin
        ns_of[i] = ns_mask_q[i-1];
      end else begin
        ns_of[i] = '0;
      end
      if (i == 0) begin
        reinit_val[i] = init_a_q;
      end else begin
        reinit_val[i] = (stop_q[i] & ns_of[i]) | ~ns_of[i];
      end
    end
  end

  assign r_idx    = reg_q[RW-1:0];
  assign bit_mask = REG_W'(1) << bit_q[BIT_IDX_W-1:0];
  assign stop_old = stop_q[r_idx];
  assign cnt_prev = cnt_vld_q[addr_q] ? rd_q : '0;

  always_comb begin
    status_res  = ST_OK;
    cnt_new     = cnt_prev;
    mem_we      = 1'b0;
    stop_wr     = 1'b0;
    stop_cand   = stop_old;
    stop_new    = stop_old;
    stopped_res = 1'b0;
    if (kind_q == OP_REINIT) begin
      cnt_new = '0;
      if (id_ok_q) begin
        stopped_res = |(reinit_val[r_idx] & bit_mask);
      end
    end else if (!id_ok_q) begin
      status_res = ST_BAD_ARG;
      cnt_new    = '0;
    end else begin
      unique case (kind_q)
        OP_ENABLE: begin
          if (cnt_prev == COUNT_MAX) begin
            status_res = ST_BAD_STATE;
          end else begin
            mem_we  = 1'b1;
            cnt_new = COUNT_W'(cnt_prev + 1'b1);
            if (cnt_prev == '0) begin
              stop_wr   = 1'b1;
              stop_cand = stop_old & ~bit_mask;
              stop_new  = (stop_old & ns_of[r_idx]) | (stop_cand & ~ns_of[r_idx]);
              if ((stop_new & bit_mask) != '0) begin
                cnt_new    = cnt_prev;
                status_res = ST_TIMEOUT;
              end
            end
          end
        end
        OP_DISABLE: begin
          if (cnt_prev == '0) begin
            status_res = ST_BAD_STATE;
          end else begin
            mem_we  = 1'b1;
            cnt_new = COUNT_W'(cnt_prev - 1'b1);
            if (cnt_prev == COUNT_W'(1)) begin
              stop_wr   = 1'b1;
              stop_cand = stop_old | bit_mask;
              stop_new  = (stop_old & ns_of[r_idx]) | (stop_cand & ~ns_of[r_idx]);
              if ((stop_new & bit_mask) == '0) begin
                cnt_new    = cnt_prev;
                status_res = ST_TIMEOUT;
              end
            end
          end
        end
        default: ;
      endcase
      stopped_res = stop_wr ? |(stop_new & bit_mask) : |(stop_old & bit_mask);
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done && mem_we) begin
      mem[addr_q] <= cnt_new;
    end
    if (accept) begin
      rd_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_vld_q   <= '0;
      out_valid_q <= 1'b0;
      init_a_q    <= SAFE_STOPPED_A;
      for (int i = 0; i < NS_REGS; i++) begin
        ns_mask_q[i] <= '0;
      end
      for (int i = 0; i < GATE_REGISTERS; i++) begin
        stop_q[i] <= (i == 0) ? SAFE_STOPPED_A : ALL_STOPPED;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_INIT_PATTERN_A: init_a_q     <= cfg_wdata_i;
          CFG_NS_MASK_B:      ns_mask_q[0] <= cfg_wdata_i;
          CFG_NS_MASK_C:      ns_mask_q[1] <= cfg_wdata_i;
          CFG_NS_MASK_D:      ns_mask_q[2] <= cfg_wdata_i;
          CFG_NS_MASK_E:      ns_mask_q[3] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (exec_done) begin
        out_valid_q <= 1'b1;
        if (kind_q == OP_REINIT) begin
          cnt_vld_q <= '0;
          for (int i = 0; i < GATE_REGISTERS; i++) begin
            stop_q[i] <= reinit_val[i];
          end
        end else begin
          if (mem_we) begin
            cnt_vld_q[addr_q] <= 1'b1;
          end
          if (stop_wr) begin
            stop_q[r_idx] <= stop_new;
          end
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= op_e'(in_kind_i);
      reg_q   <= in_reg;
      bit_q   <= in_bit;
      id_ok_q <= in_id_ok;
      addr_q  <= in_addr;
    end
    if (exec_done) begin
      out_status_q <= status_res;
      out_count_q  <= cnt_new;
      out_halted_q <= stopped_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_use_count_o = out_count_q;
  assign out_halted_o    = out_halted_q;

`ifndef SYNTHESIS
  a_done_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_done |=> out_valid_o)
    else $error("finished request did not present a result word");

  a_write_only_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && exec_done) |-> (state_q == S_EXEC) && id_ok_q)
    else $error("count store written outside a valid request");

  a_bad_arg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_status_o == ST_BAD_ARG) |-> (out_use_count_o == '0) && !out_halted_o)
    else $error("invalid id reported nonzero state");

  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_done && kind_q == OP_REINIT) |=> (cnt_vld_q == '0))
    else $error("re-init left counts valid");
`endif

endmodule

`default_nettype wire

### tb/refcounted_module_gate_control_tb.sv
`timescale 1ns / 1ps

module refcounted_module_gate_control_tb;
  import rcmgc_pkg::*;

  localparam int NUM_REGS = 5;
  localparam int NUM_BITS = 32;

  typedef struct {
    logic             is_cfg;
    op_e              op;
    logic [ID_W-1:0]  id;
    cfg_idx_e         cidx;
    logic [REG_W-1:0] cdata;
  } gate_word_t;

  typedef struct {
    status_e            status;
    logic [COUNT_W-1:0] count;
    logic               stopped;
  } gate_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_e             cfg_idx = CFG_INIT_PATTERN_A;
  logic [REG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  op_e                  in_kind = OP_ENABLE;
  logic [ID_W-1:0]      in_id = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_count;
  logic                 out_halted;

  gate_word_t           word_q[$];
  gate_result_t         gate_expect_q[$];
  int unsigned          errors = 0;
  logic                 in_taken = 1'b0;
  logic                 out_taken = 1'b0;

  logic [COUNT_W-1:0]   use_cnt[NUM_REGS][NUM_BITS];
  logic [REG_W-1:0]     stop_reg[NUM_REGS];
  logic [REG_W-1:0]     init_a;
  logic [REG_W-1:0]     ns_mask[NS_REGS];

  refcounted_module_gate_control dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_kind_i      (in_kind),
    .in_module_id_i (in_id),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_status_o   (out_status),
    .out_use_count_o(out_count),
    .out_halted_o   (out_halted)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [REG_W-1:0] ns_merge(int r, logic [REG_W-1:0] val);
    logic [REG_W-1:0] ns;
    ns = (r >= 1 && r <= NS_REGS) ? ns_mask[r-1] : '0;
    return (stop_reg[r] & ns) | (val & ~ns);
  endfunction

  function automatic gate_result_t gate_predict(op_e op, logic [ID_W-1:0] id);
    int               r;
    int               b;
    logic             id_ok;
    logic [REG_W-1:0] m;
    logic [COUNT_W-1:0] prev;
    gate_result_t     res;
    r = int'(id[15:8]);
    b = int'(id[7:0]);
    id_ok = (r < NUM_REGS) && (b < NUM_BITS);
    m = id_ok ? (32'd1 << b) : '0;
    res.status = ST_OK;
    if (op == OP_REINIT) begin
      for (int rr = 0; rr < NUM_REGS; rr++) begin
        for (int bb = 0; bb < NUM_BITS; bb++) use_cnt[rr][bb] = '0;
        stop_reg[rr] = ns_merge(rr, (rr == 0) ? init_a : ALL_STOPPED);
      end
    end else if (!id_ok) begin
      res.status = ST_BAD_ARG;
    end else if (op == OP_ENABLE) begin
      prev = use_cnt[r][b];
      if (prev == COUNT_MAX) begin
        res.status = ST_BAD_STATE;
      end else begin
        use_cnt[r][b] = prev + 8'd1;
        if (prev == '0) begin
          stop_reg[r] = ns_merge(r, stop_reg[r] & ~m);
          if ((stop_reg[r] & m) != '0) begin
            use_cnt[r][b] = prev;
            res.status = ST_TIMEOUT;
          end
        end
      end
    end else if (op == OP_DISABLE) begin
      prev = use_cnt[r][b];
      if (prev == '0) begin
        res.status = ST_BAD_STATE;
      end else begin
        use_cnt[r][b] = prev - 8'd1;
        if (prev == 8'd1) begin
          stop_reg[r] = ns_merge(r, stop_reg[r] | m);
          if ((stop_reg[r] & m) == '0) begin
            use_cnt[r][b] = prev;
            res.status = ST_TIMEOUT;
          end
        end
      end
    end
    res.count = id_ok ? use_cnt[r][b] : '0;
    res.stopped = id_ok ? ((stop_reg[r] & m) != '0) : 1'b0;
    return res;
  endfunction

  function automatic void queue_op(op_e op, logic [ID_W-1:0] id);
    gate_word_t w;
    w = '{1'b0, op, id, CFG_INIT_PATTERN_A, '0};
    word_q.push_back(w);
  endfunction

  function automatic void queue_cfg(cfg_idx_e idx, logic [REG_W-1:0] data);
    gate_word_t w;
    w = '{1'b1, OP_QUERY, '0, idx, data};
    word_q.push_back(w);
  endfunction

  // Driver: one word at a time, with a random gap drawn as each request word is presented.
  int unsigned src_gap = 0;
  int unsigned src_items = 0;
  logic        src_fast = 1'b0;

  always @(negedge clk) begin : driver
    gate_word_t w;
    logic       nxt_valid;
    logic       nxt_we;
    nxt_valid = in_valid;
    nxt_we = 1'b0;
    if (rst_n) begin
      if (in_valid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (word_q.size() > 0) begin
          if (word_q[0].is_cfg) begin
            if (!in_valid && gate_expect_q.size() == 0) begin
              w = word_q.pop_front();
              cfg_idx <= w.cidx;
              cfg_wdata <= w.cdata;
              nxt_we = 1'b1;
            end
          end else begin
            w = word_q.pop_front();
            in_kind <= w.op;
            in_id <= w.id;
            nxt_valid = 1'b1;
            src_items++;
            if (src_items % 32 == 0) src_fast = ($urandom_range(0, 2) == 0);
            src_gap = src_fast ? 0 : $urandom_range(0, 9);
          end
        end
      end
    end
    in_valid <= nxt_valid;
    cfg_we <= nxt_we;
  end

  // Receiver: random stall per word, plus two long hold-offs to back up the block.
  int unsigned sink_wait = 0;
  int unsigned rx_count = 0;
  logic        sink_fast = 1'b0;

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (out_taken) begin
        rx_count++;
        if (rx_count % 24 == 0) sink_fast = ($urandom_range(0, 2) == 0);
        if (rx_count == 60 || rx_count == 400) sink_wait = 150;
        else sink_wait = sink_fast ? 0 : $urandom_range(0, 9);
      end
      if (sink_wait > 0 && out_valid) begin
        sink_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    gate_result_t e;
    in_taken = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (out_taken) begin
      if (gate_expect_q.size() == 0) begin
        errors++;
        $display("%0t: word out with none expected (status %0d count %0d stopped %0b)",
                 $time, out_status, out_count, out_halted);
      end else begin
        e = gate_expect_q.pop_front();
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, e.status, out_status);
        end
        if (out_count !== e.count) begin
          errors++;
          $display("%0t: use_count expected %0d got %0d", $time, e.count, out_count);
        end
        if (out_halted !== e.stopped) begin
          errors++;
          $display("%0t: stopped expected %0b got %0b", $time, e.stopped, out_halted);
        end
      end
    end
    if (rst_n && cfg_we) begin
      if (cfg_idx == CFG_INIT_PATTERN_A) init_a = cfg_wdata;
      else ns_mask[cfg_idx - CFG_NS_MASK_B] = cfg_wdata;
    end
    if (in_taken) gate_expect_q.push_back(gate_predict(in_kind, in_id));
  end

  initial begin
    int               n;
    int               sel;
    int               k;
    logic [7:0]       r;
    logic [7:0]       b;
    logic [ID_W-1:0]  id;
    op_e              op;
    init_a = SAFE_STOPPED_A;
    for (int i = 0; i < NS_REGS; i++) ns_mask[i] = '0;
    for (int rr = 0; rr < NUM_REGS; rr++) begin
      for (int bb = 0; bb < NUM_BITS; bb++) use_cnt[rr][bb] = '0;
      stop_reg[rr] = (rr == 0) ? SAFE_STOPPED_A : ALL_STOPPED;
    end

    queue_op(OP_QUERY, 16'h0000);
    queue_op(OP_QUERY, 16'h0004);
    queue_op(OP_ENABLE, 16'h0000);
    queue_op(OP_DISABLE, 16'h0000);
    queue_op(OP_DISABLE, 16'h0000);
    queue_op(OP_ENABLE, 16'h041F);
    queue_op(OP_QUERY, 16'h041F);
    queue_op(OP_DISABLE, 16'h041F);
    queue_op(OP_ENABLE, 16'h0500);
    queue_op(OP_DISABLE, 16'h0020);
    queue_op(OP_QUERY, 16'hFFFF);
    queue_op(OP_ENABLE, 16'h00FF);
    queue_op(OP_QUERY, 16'h8080);
    queue_op(OP_REINIT, 16'hFFFF);
    queue_op(OP_REINIT, 16'h0003);
    for (n = 0; n < 256; n++) queue_op(OP_ENABLE, 16'h0102);
    queue_op(OP_QUERY, 16'h0102);
    queue_op(OP_DISABLE, 16'h0102);
    queue_op(OP_ENABLE, 16'h0203);

    queue_cfg(CFG_NS_MASK_B, 32'h0000_0108);
    queue_cfg(CFG_NS_MASK_C, 32'h8000_0008);
    queue_op(OP_ENABLE, 16'h0108);
    queue_op(OP_ENABLE, 16'h0103);
    queue_op(OP_DISABLE, 16'h0203);
    queue_op(OP_REINIT, 16'h0203);
    queue_op(OP_QUERY, 16'h0108);

    queue_cfg(CFG_INIT_PATTERN_A, 32'h0000_0000);
    queue_cfg(CFG_NS_MASK_D, 32'hFFFF_FFFF);
    queue_cfg(CFG_NS_MASK_E, 32'hFFFF_FFFF);
    queue_op(OP_REINIT, 16'h0000);
    queue_op(OP_ENABLE, 16'h0305);
    queue_op(OP_ENABLE, 16'h0405);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          queue_cfg(CFG_INIT_PATTERN_A, ALL_STOPPED);
          queue_cfg(CFG_NS_MASK_B, '0);
          queue_cfg(CFG_NS_MASK_C, '0);
          queue_cfg(CFG_NS_MASK_D, '0);
          queue_cfg(CFG_NS_MASK_E, '0);
        end
        2: begin
          queue_cfg(CFG_INIT_PATTERN_A, '0);
          queue_cfg(CFG_NS_MASK_B, ALL_STOPPED);
          queue_cfg(CFG_NS_MASK_C, $urandom() & $urandom() & $urandom());
          queue_cfg(CFG_NS_MASK_D, $urandom() & $urandom() & $urandom());
          queue_cfg(CFG_NS_MASK_E, $urandom() & $urandom());
        end
        default: begin
          queue_cfg(CFG_INIT_PATTERN_A, $urandom());
          queue_cfg(CFG_NS_MASK_B, $urandom() & $urandom() & $urandom());
          queue_cfg(CFG_NS_MASK_C, $urandom() & $urandom());
          queue_cfg(CFG_NS_MASK_D, $urandom() & $urandom() & $urandom());
          queue_cfg(CFG_NS_MASK_E, $urandom());
        end
      endcase
      if ($urandom_range(0, 1) == 0) queue_op(OP_REINIT, 16'($urandom()));
      for (n = 0; n < 40; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
          id = 16'($urandom());
        end else begin
          r = 8'($urandom_range(0, NUM_REGS - 1));
          case ($urandom_range(0, 5))
            0: b = 8'd0;
            1: b = 8'd7;
            2: b = 8'd19;
            3: b = 8'd31;
            default: b = 8'($urandom_range(0, NUM_BITS - 1));
          endcase
          id = {r, b};
        end
        k = $urandom_range(0, 99);
        if (k < 45) op = OP_ENABLE;
        else if (k < 80) op = OP_DISABLE;
        else if (k < 95) op = OP_QUERY;
        else op = OP_REINIT;
        queue_op(op, id);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (word_q.size() > 0 || in_valid || gate_expect_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("%0t: timeout, %0d words still expected", $time, gate_expect_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
